[rtl/jsu_pkg.sv]
// jsu_pkg: shared types and symbol codes for the jacobi symbol unit
`default_nettype none
package jsu_pkg;

    localparam logic [1:0] SYM_ZERO = 2'b00;
    localparam logic [1:0] SYM_POS  = 2'b01;
    localparam logic [1:0] SYM_NEG  = 2'b11;

    typedef struct packed {
        logic valid;
        logic neg;
        logic bad;
    } t_step_ctl;

endpackage
`default_nettype wire

[rtl/jsu_mod_stage.sv]
// jsu_mod_stage: one restoring step of the numerator reduction modulo b
`default_nettype none
module jsu_mod_stage
    import jsu_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire t_step_ctl    i_ctl,
    input  wire logic [W-1:0] i_mag,
    input  wire logic [W-2:0] i_rem,
    input  wire logic [W-2:0] i_b,
    output t_step_ctl         o_ctl,
    output logic [W-1:0]      o_mag,
    output logic [W-2:0]      o_rem,
    output logic [W-2:0]      o_b
);
    logic [W-1:0] ext;
    logic [W-1:0] dif;
    logic [W-2:0] n_rem;
    logic         r_valid;
    t_step_ctl    r_ctl;
    logic [W-1:0] r_mag;
    logic [W-2:0] r_rem;
    logic [W-2:0] r_b;

    always_comb begin
        ext   = {i_rem, i_mag[W-1]};
        dif   = ext - {1'b0, i_b};
        n_rem = (ext >= {1'b0, i_b}) ? dif[W-2:0] : ext[W-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_mag <= {i_mag[W-2:0], 1'b0};
            r_rem <= n_rem;
            r_b   <= i_b;
        end
    end

    always_comb begin
        o_ctl       = r_ctl;
        o_ctl.valid = r_valid;
    end
    assign o_mag = r_mag;
    assign o_rem = r_rem;
    assign o_b   = r_b;
endmodule
`default_nettype wire

[rtl/jsu_core_stage.sv]
// jsu_core_stage: one step of the binary jacobi iteration
`default_nettype none
module jsu_core_stage
    import jsu_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire t_step_ctl    i_ctl,
    input  wire logic [W-2:0] i_a,
    input  wire logic [W-2:0] i_b,
    output t_step_ctl         o_ctl,
    output logic [W-2:0]      o_a,
    output logic [W-2:0]      o_b
);
    logic [W-2:0] n_a;
    logic [W-2:0] n_b;
    logic         n_neg;
    logic         r_valid;
    t_step_ctl    r_ctl;
    logic [W-2:0] r_a;
    logic [W-2:0] r_b;

    // neg field carries the running sign of the symbol
    always_comb begin
        n_a   = i_a;
        n_b   = i_b;
        n_neg = i_ctl.neg;
        if (i_a == '0) begin
            n_a = i_a;
        end else if (!i_a[0]) begin
            n_a = i_a >> 1;
            if (i_b[2:0] == 3'd3 || i_b[2:0] == 3'd5) begin
                n_neg = ~i_ctl.neg;
            end
        end else if (i_a >= i_b) begin
            n_a = i_a - i_b;
        end else begin
            n_a = i_b - i_a;
            n_b = i_a;
            if (i_a[1:0] == 2'd3 && i_b[1:0] == 2'd3) begin
                n_neg = ~i_ctl.neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= '{valid: i_ctl.valid, neg: n_neg, bad: i_ctl.bad};
            r_a   <= n_a;
            r_b   <= n_b;
        end
    end

    always_comb begin
        o_ctl       = r_ctl;
        o_ctl.valid = r_valid;
    end
    assign o_a = r_a;
    assign o_b = r_b;
endmodule
`default_nettype wire

[rtl/jacobi_symbol_unit.sv]
// jacobi_symbol_unit: pipelined jacobi symbol (a/b) evaluator
//
// slave channel: one word carries numerator a (signed) and modulus b (odd).
// master channel: one word carries the symbol -1/0/+1 and a bad modulus flag.
// the numerator is reduced mod b in WORD_BITS restoring stages, one quotient
// bit per stage, then one stage forms the non-negative residue, then
// 4*(WORD_BITS-1)+2 binary jacobi stages each remove a factor of two or
// subtract, then one output register.
// throughput: one word per cycle while the master side accepts; every stage is a registered step.
// a stall on the master side freezes the whole pipeline; nothing is lost
// or repeated, and s_tready is low while the output word waits.
// reset clears all valid bits; payload registers are not reset.
// an even or zero modulus gives symbol 0 with the flag set.
`default_nettype none
module jacobi_symbol_unit
    import jsu_pkg::*;
#(
    parameter int WORD_BITS = 32,
    localparam int IN_BYTES = (2 * WORD_BITS - 1 + 7) / 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // top_value [WORD_BITS-1:0], modulus [2*WORD_BITS-2:WORD_BITS], zero pad
    input  wire logic [IN_BYTES*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // symbol [1:0], zero pad
    output logic [7:0]                m_tdata,
    // bad_modulus [0]
    output logic                      m_tuser
);
    localparam int W        = WORD_BITS;
    localparam int NCORE    = 4 * (W - 1) + 2;

    logic         en;
    logic [W-1:0] in_a;
    logic [W-2:0] in_b;
    logic [W-1:0] mag0;
    t_step_ctl    ctl0;

    t_step_ctl    m_ctl [W+1];
    logic [W-1:0] m_mag [W+1];
    logic [W-2:0] m_rem [W+1];
    logic [W-2:0] m_b   [W+1];

    t_step_ctl    c_ctl [NCORE+1];
    logic [W-2:0] c_a   [NCORE+1];
    logic [W-2:0] c_b   [NCORE+1];

    logic         r_fix_valid;
    t_step_ctl    r_fix_ctl;
    logic [W-2:0] r_fix_a;
    logic [W-2:0] r_fix_b;

    logic         r_out_valid;
    logic [1:0]   r_sym;
    logic         r_bad;
    logic [1:0]   n_sym;
    t_step_ctl    fin;

    assign en       = !r_out_valid || m_tready;
    assign s_tready = en;

    assign in_a = s_tdata[W-1:0];
    assign in_b = s_tdata[2*W-2:W];
    assign mag0 = in_a[W-1] ? (~in_a + W'(1)) : in_a;

    always_comb begin
        ctl0.valid = s_tvalid;
        ctl0.neg   = in_a[W-1];
        ctl0.bad   = (in_b == '0) || !in_b[0];
    end

    assign m_ctl[0] = ctl0;
    assign m_mag[0] = mag0;
    assign m_rem[0] = '0;
    assign m_b[0]   = in_b;

    for (genvar k = 0; k < W; k++) begin : g_mod
        jsu_mod_stage #(.W(W)) u_mod (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (m_ctl[k]),
            .i_mag   (m_mag[k]),
            .i_rem   (m_rem[k]),
            .i_b     (m_b[k]),
            .o_ctl   (m_ctl[k+1]),
            .o_mag   (m_mag[k+1]),
            .o_rem   (m_rem[k+1]),
            .o_b     (m_b[k+1])
        );
    end

    // negative numerator with a nonzero remainder r: residue becomes b - r
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix_valid <= 1'b0;
        end else if (en) begin
            r_fix_valid <= m_ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fix_ctl <= '{valid: m_ctl[W].valid, neg: 1'b0, bad: m_ctl[W].bad};
            r_fix_b   <= m_b[W];
            if (m_ctl[W].neg && m_rem[W] != '0) begin
                r_fix_a <= m_b[W] - m_rem[W];
            end else begin
                r_fix_a <= m_rem[W];
            end
        end
    end

    assign c_ctl[0] = '{valid: r_fix_valid, neg: r_fix_ctl.neg, bad: r_fix_ctl.bad};
    assign c_a[0]   = r_fix_a;
    assign c_b[0]   = r_fix_b;

    for (genvar k = 0; k < NCORE; k++) begin : g_core
        jsu_core_stage #(.W(W)) u_core (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (c_ctl[k]),
            .i_a     (c_a[k]),
            .i_b     (c_b[k]),
            .o_ctl   (c_ctl[k+1]),
            .o_a     (c_a[k+1]),
            .o_b     (c_b[k+1])
        );
    end

    assign fin = c_ctl[NCORE];

    always_comb begin
        if (fin.bad) begin
            n_sym = SYM_ZERO;
        end else if (c_a[NCORE] == '0 && c_b[NCORE] == {{(W-2){1'b0}}, 1'b1}) begin
            n_sym = fin.neg ? SYM_NEG : SYM_POS;
        end else begin
            n_sym = SYM_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sym <= n_sym;
            r_bad <= fin.bad;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'b0, r_sym};
    assign m_tuser  = r_bad;
endmodule
`default_nettype wire

[tb/testbench.sv]
// testbench: streams numerator/modulus words through jacobi_symbol_unit and checks each symbol
`default_nettype none
module testbench;
    import jsu_pkg::*;

    typedef struct packed {
        logic [1:0] sym;
        logic       bad;
    } sym_word_t;

    typedef struct {
        logic [31:0] num;
        logic [30:0] modulus;
        logic        fixed;
        sym_word_t   want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    sym_word_t pending_symbols[$];
    int        mismatches = 0;
    bit        quiet = 1'b0;

    jacobi_symbol_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic sym_word_t jacobi_of(logic [31:0] num, logic [30:0] modulus);
        longint unsigned x, y, mag, tmp;
        int sgn;
        sym_word_t res;
        res = '{sym: SYM_ZERO, bad: 1'b0};
        if (modulus == 0 || !modulus[0]) begin
            res.bad = 1'b1;
            return res;
        end
        y = {33'd0, modulus};
        mag = num[31] ? {32'd0, (~num) + 32'd1} : {32'd0, num};
        x = mag % y;
        if (num[31] && x != 0) x = y - x;
        sgn = 1;
        while (x != 0) begin
            while (x[0] == 1'b0) begin
                x = x >> 1;
                if (y[2:0] == 3'd3 || y[2:0] == 3'd5) sgn = -sgn;
            end
            tmp = x;
            x = y;
            y = tmp;
            if (x[1:0] == 2'd3 && y[1:0] == 2'd3) sgn = -sgn;
            x = x % y;
        end
        if (y == 1) res.sym = (sgn < 0) ? SYM_NEG : SYM_POS;
        return res;
    endfunction

    task automatic send_word(logic [31:0] num, logic [30:0] modulus, logic fixed,
                             sym_word_t want, bit gap_after);
        s_tdata  <= {1'b0, modulus, num};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        pending_symbols.push_back(fixed ? want : jacobi_of(num, modulus));
        if (gap_after) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // receiver: long hold-off first, then random stall bursts
    initial begin
        int hold;
        @(posedge i_rst_n);
        hold = 0;
        while (hold < 400) begin
            @(posedge i_clk);
            hold++;
        end
        forever begin
            if (quiet || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_symbols.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: symbol %b bad %b", m_tdata[1:0], m_tuser);
            end else begin
                sym_word_t w;
                w = pending_symbols.pop_front();
                if (m_tdata[1:0] !== w.sym || m_tuser !== w.bad
                        || m_tdata[7:2] !== 6'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("symbol word: expected %b/%b got %b/%b (tdata %h)",
                                 w.sym, w.bad, m_tdata[1:0], m_tuser, m_tdata);
                end
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        logic [31:0] num;
        logic [30:0] modulus;
        int kind;
        sym_word_t none;
        none = '{sym: SYM_ZERO, bad: 1'b0};
        rows = '{
            '{32'd5,          31'd0,          1'b1, '{SYM_ZERO, 1'b1}},
            '{32'hFFFF_FFFF,  31'd8,          1'b1, '{SYM_ZERO, 1'b1}},
            '{32'h8000_0000,  31'h7FFF_FFFE,  1'b1, '{SYM_ZERO, 1'b1}},
            '{32'd0,          31'd1,          1'b1, '{SYM_POS, 1'b0}},
            '{32'h8000_0000,  31'd1,          1'b1, '{SYM_POS, 1'b0}},
            '{32'h7FFF_FFFF,  31'd1,          1'b1, '{SYM_POS, 1'b0}},
            '{32'd0,          31'd3,          1'b1, '{SYM_ZERO, 1'b0}},
            '{32'd0,          31'h7FFF_FFFF,  1'b1, '{SYM_ZERO, 1'b0}},
            '{32'd9,          31'd3,          1'b1, '{SYM_ZERO, 1'b0}},
            '{32'd1,          31'd7,          1'b1, '{SYM_POS, 1'b0}},
            '{32'hFFFF_FFFF,  31'd3,          1'b1, '{SYM_NEG, 1'b0}},
            '{32'd2,          31'd3,          1'b0, none},
            '{32'd2,          31'd7,          1'b0, none},
            '{32'd3,          31'd7,          1'b0, none},
            '{32'hFFFF_FFFD,  31'd15,         1'b0, none},
            '{32'h8000_0000,  31'h7FFF_FFFF,  1'b0, none},
            '{32'h7FFF_FFFF,  31'h7FFF_FFFF,  1'b0, none},
            '{32'h7FFF_FFFE,  31'h7FFF_FFFF,  1'b0, none},
            '{32'h8000_0001,  31'h7FFF_FFFD,  1'b0, none},
            '{32'h1234_5678,  31'h5555_5555,  1'b0, none},
            '{32'hDEAD_BEEF,  31'h2AAA_AAAB,  1'b0, none},
            '{32'd1001,       31'd1001,       1'b0, none}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i])
            send_word(rows[i].num, rows[i].modulus, rows[i].fixed, rows[i].want,
                      $urandom_range(0, 2) == 0);
        for (int n = 0; n < 1000; n++) begin
            kind = $urandom_range(0, 9);
            num = $urandom;
            case (kind)
                0: modulus = 31'($urandom);
                1, 2: modulus = 31'($urandom | 1);
                3: begin
                    modulus = 31'($urandom_range(1, 99) | 1);
                    num = $signed(modulus) * ($signed($urandom_range(0, 2000)) - 1000);
                end
                default: modulus = 31'($urandom_range(1, 999) | 1);
            endcase
            if (n > 850) quiet = 1'b1;
            send_word(num, modulus, 1'b0, none, !quiet && $urandom_range(0, 3) == 0);
        end
        s_tvalid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_symbols.size() == 0)
            $display("jacobi_symbol_unit: match");
        else
            $display("jacobi_symbol_unit: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("jacobi_symbol_unit: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
